// ===== design/assert_macros.svh =====
// Assertion macros used by planar_chain_forward_kinematics.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/pfk_pkg.sv =====
// ---------------------------------------------------------------------------
// pfk_pkg
// Types, constants and the arctangent table of the planar chain block.
// ---------------------------------------------------------------------------
package pfk_pkg;

   localparam int NumBones    = 4;
   localparam int CordicSteps = 16;
   localparam int VecW        = 35;
   localparam int AngW        = 25;
   localparam int DeltaW      = 20;
   localparam int PosW        = 24;
   localparam logic [15:0] GainQ16 = 16'd39796;

   localparam logic [2:0] CsrBaseX  = 3'd0;
   localparam logic [2:0] CsrBaseY  = 3'd1;
   localparam logic [2:0] CsrCount  = 3'd2;
   localparam logic [2:0] CsrLen0   = 3'd3;
   localparam logic [2:0] CsrLen1   = 3'd4;
   localparam logic [2:0] CsrLen2   = 3'd5;
   localparam logic [2:0] CsrLen3   = 3'd6;

   typedef struct packed {
      logic                   valid;
      logic [1:0]             bone;
      logic                   flip;
      logic signed [VecW-1:0] x;
      logic signed [VecW-1:0] y;
      logic signed [AngW-1:0] z;
   } cell_type;

   function automatic logic signed [AngW-1:0] atan_turn(input logic [3:0] step);
      logic signed [AngW-1:0] v;
      unique case (step)
         4'd0:  v = 25'sd2097152;
         4'd1:  v = 25'sd1238021;
         4'd2:  v = 25'sd654136;
         4'd3:  v = 25'sd332050;
         4'd4:  v = 25'sd166669;
         4'd5:  v = 25'sd83416;
         4'd6:  v = 25'sd41718;
         4'd7:  v = 25'sd20860;
         4'd8:  v = 25'sd10430;
         4'd9:  v = 25'sd5215;
         4'd10: v = 25'sd2608;
         4'd11: v = 25'sd1304;
         4'd12: v = 25'sd652;
         4'd13: v = 25'sd326;
         4'd14: v = 25'sd163;
         default: v = 25'sd81;
      endcase
      return v;
   endfunction

endpackage

// ===== design/planar_chain_forward_kinematics.sv =====
// ---------------------------------------------------------------------------
// planar_chain_forward_kinematics
// Joint positions of a planar chain of up to four bones from bone angles.
// ---------------------------------------------------------------------------
// A request word sets the absolute angle of one bone. The block then sends
// one response word for each joint, from the base (joint 0) out to joint
// bone_count (1 if zero, 4 if above), with last set on the final one. A bone
// index not below that count gives one word with rejected and last set,
// and changes nothing. The user must write the base position, bone count
// and lengths by the csr port while the block is idle; it is not enforced.
// Each bone vector is found by a row of sixteen CORDIC cells; the bones
// enter it on consecutive cycles after one multiply stage, so the first
// response word appears once the last bone has left the row, and
// the remaining words follow one a cycle while the receiver takes them.
// One request is worked at a time: a new one is taken only after the
// last word of a run has been taken. A stalled receiver holds the
// current word and the block waits. Reset puts all angles at zero, the
// base at the origin, four bones of length 256, and empties the row.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module planar_chain_forward_kinematics (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_joint_index,
   input  logic [15:0]        req_new_angle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_joint_number,
   output logic signed [23:0] rsp_pos_x,
   output logic signed [23:0] rsp_pos_y,
   output logic               rsp_rejected,
   output logic               rsp_last,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wdata
);

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StCalc = 2'd1;
   localparam logic [1:0] StEmit = 2'd2;
   localparam logic [1:0] StRej  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic signed [23:0] base_x_ff, base_y_ff;
   logic [2:0]  bone_count_ff;
   logic [15:0] len_ff [pfk_pkg::NumBones];
   logic [15:0] angle_ff [pfk_pkg::NumBones];
   logic [2:0]  cnt_ff, issue_ff, col_ff, jnt_ff;
   logic signed [pfk_pkg::DeltaW-1:0] dx_ff [pfk_pkg::NumBones];
   logic signed [pfk_pkg::DeltaW-1:0] dy_ff [pfk_pkg::NumBones];
   logic signed [23:0] pos_x_ff, pos_y_ff;
   pfk_pkg::cell_type  head_ff;
   pfk_pkg::cell_type  row [pfk_pkg::CordicSteps+1];

   logic [2:0]  eff_cnt;
   logic        req_fire, rsp_fire, issuing;
   logic [1:0]  ib;
   logic [15:0] ang, resid;
   logic        flip;
   logic [31:0] prod;
   pfk_pkg::cell_type tail;
   logic signed [pfk_pkg::VecW-1:0] rx, ry;
   logic signed [pfk_pkg::DeltaW-1:0] tx, ty;

   function automatic logic signed [23:0] sat_add(input logic signed [23:0] p,
                                                  input logic signed [19:0] d);
      logic signed [25:0] s;
      s = 26'(p) + 26'(d);
      if (s > 26'sd8388607) return 24'sd8388607;
      if (s < -26'sd8388608) return -24'sd8388608;
      return s[23:0];
   endfunction

   always_comb begin
      if (bone_count_ff == 3'd0) eff_cnt = 3'd1;
      else if (bone_count_ff > 3'd4) eff_cnt = 3'd4;
      else eff_cnt = bone_count_ff;
   end

   assign req_ready = (state_ff == StIdle);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (state_ff == StEmit) || (state_ff == StRej);
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign issuing   = (state_ff == StCalc) && (issue_ff < cnt_ff);
   assign ib        = issue_ff[1:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         StIdle: if (req_fire) begin
            state_in = ({1'b0, req_joint_index} >= eff_cnt) ? StRej : StCalc;
         end
         StCalc: if (col_ff == cnt_ff) state_in = StEmit;
         StEmit: if (rsp_fire && jnt_ff == cnt_ff) state_in = StIdle;
         default: if (rsp_fire) state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= StIdle;
         base_x_ff     <= '0;
         base_y_ff     <= '0;
         bone_count_ff <= 3'd4;
         for (int i = 0; i < pfk_pkg::NumBones; i++) begin
            len_ff[i]   <= 16'd256;
            angle_ff[i] <= '0;
         end
         cnt_ff   <= 3'd1;
         issue_ff <= '0;
         col_ff   <= '0;
         jnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               pfk_pkg::CsrBaseX: base_x_ff     <= csr_wdata;
               pfk_pkg::CsrBaseY: base_y_ff     <= csr_wdata;
               pfk_pkg::CsrCount: bone_count_ff <= csr_wdata[2:0];
               pfk_pkg::CsrLen0:  len_ff[0]     <= csr_wdata[15:0];
               pfk_pkg::CsrLen1:  len_ff[1]     <= csr_wdata[15:0];
               pfk_pkg::CsrLen2:  len_ff[2]     <= csr_wdata[15:0];
               pfk_pkg::CsrLen3:  len_ff[3]     <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_fire) begin
            cnt_ff   <= eff_cnt;
            issue_ff <= '0;
            col_ff   <= '0;
            jnt_ff   <= '0;
            if ({1'b0, req_joint_index} < eff_cnt) begin
               angle_ff[req_joint_index] <= req_new_angle;
            end
         end
         if (issuing) issue_ff <= issue_ff + 3'd1;
         if (tail.valid) col_ff <= col_ff + 3'd1;
         if (state_ff == StEmit && rsp_fire) jnt_ff <= jnt_ff + 3'd1;
      end
   end

   // Quadrant fold, start vector and entry into the cell row.
   always_comb begin
      ang   = angle_ff[ib];
      flip  = ang[15] ^ ang[14];
      resid = flip ? (ang - 16'h8000) : ang;
      prod  = 32'(len_ff[ib]) * 32'(pfk_pkg::GainQ16);
   end

   always_ff @(posedge clock) begin
      head_ff.bone <= ib;
      head_ff.flip <= flip;
      head_ff.x    <= pfk_pkg::VecW'(prod);
      head_ff.y    <= '0;
      head_ff.z    <= pfk_pkg::AngW'($signed({resid, 8'd0}));
      head_ff.valid <= reset ? 1'b0 : issuing;
   end

   assign row[0] = head_ff;

   for (genvar g = 0; g < pfk_pkg::CordicSteps; g++) begin : g_cell
      pfk_cordic_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .step     (4'(g)),
         .cell_in  (row[g]),
         .cell_out (row[g+1])
      );
   end

   assign tail = row[pfk_pkg::CordicSteps];

   always_comb begin
      rx = tail.x + pfk_pkg::VecW'(32768);
      ry = tail.y + pfk_pkg::VecW'(32768);
      tx = pfk_pkg::DeltaW'($signed(rx[pfk_pkg::VecW-1:16]));
      ty = pfk_pkg::DeltaW'($signed(ry[pfk_pkg::VecW-1:16]));
      if (tail.flip) begin
         tx = -tx;
         ty = -ty;
      end
   end

   always_ff @(posedge clock) begin
      if (tail.valid) begin
         dx_ff[tail.bone] <= tx;
         dy_ff[tail.bone] <= ty;
      end
      if (req_fire) begin
         pos_x_ff <= base_x_ff;
         pos_y_ff <= base_y_ff;
      end else if (state_ff == StEmit && rsp_fire && jnt_ff != cnt_ff) begin
         pos_x_ff <= sat_add(pos_x_ff, dx_ff[jnt_ff[1:0]]);
         pos_y_ff <= sat_add(pos_y_ff, dy_ff[jnt_ff[1:0]]);
      end
   end

   assign rsp_rejected     = (state_ff == StRej);
   assign rsp_joint_number = rsp_rejected ? 3'd0 : jnt_ff;
   assign rsp_pos_x        = rsp_rejected ? 24'sd0 : pos_x_ff;
   assign rsp_pos_y        = rsp_rejected ? 24'sd0 : pos_y_ff;
   assign rsp_last         = rsp_rejected || (jnt_ff == cnt_ff);

   `ASSERT_SAME(a_no_rsp_when_ready, clock, reset, req_ready, !rsp_valid)
   `ASSERT_SAME(a_joint_in_range, clock, reset, state_ff == StEmit, jnt_ff <= cnt_ff)
   `ASSERT_SAME(a_row_idle_outside_calc, clock, reset, tail.valid, state_ff == StCalc)
   `ASSERT_NEXT(a_last_ends_run, clock, reset, rsp_fire && rsp_last, req_ready)

endmodule

// ===== design/pfk_cordic_cell.sv =====
// ---------------------------------------------------------------------------
// pfk_cordic_cell
// One rotation step of the CORDIC row, registered towards the next cell.
// ---------------------------------------------------------------------------
module pfk_cordic_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic [3:0]         step,
   input  pfk_pkg::cell_type  cell_in,
   output pfk_pkg::cell_type  cell_out
);

   pfk_pkg::cell_type cell_ff, cell_in_next;
   logic signed [pfk_pkg::VecW-1:0] xs, ys;
   logic signed [pfk_pkg::AngW-1:0] at;

   always_comb begin
      xs = cell_in.x >>> step;
      ys = cell_in.y >>> step;
      at = pfk_pkg::atan_turn(step);
      cell_in_next = cell_in;
      if (!cell_in.z[pfk_pkg::AngW-1]) begin
         cell_in_next.x = cell_in.x - ys;
         cell_in_next.y = cell_in.y + xs;
         cell_in_next.z = cell_in.z - at;
      end else begin
         cell_in_next.x = cell_in.x + ys;
         cell_in_next.y = cell_in.y - xs;
         cell_in_next.z = cell_in.z + at;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in_next;
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end
   end

   assign cell_out = cell_ff;

endmodule
